// ===== design/rcsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcsfd_pkg
// Shared constants and types of the RC serial frame decoder.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CHAN_W    = 11;
   localparam int unsigned SCALED_W  = 12;
   localparam int unsigned CMD_W     = 11;
   localparam int unsigned THR_W     = 12;
   localparam int unsigned POS_W     = 5;
   localparam int unsigned RSP_BITS  = 3 * CHAN_W + 2 * CMD_W + THR_W + 1;
   localparam int unsigned RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [BYTE_W-1:0] START_BYTE = 8'h0F;
   localparam logic [BYTE_W-1:0] END_BYTE   = 8'h00;

   localparam logic [POS_W-1:0] POS_B1    = 5'd1;
   localparam logic [POS_W-1:0] POS_B2    = 5'd2;
   localparam logic [POS_W-1:0] POS_B3    = 5'd3;
   localparam logic [POS_W-1:0] POS_B4    = 5'd4;
   localparam logic [POS_W-1:0] POS_FLAGS = 5'd23;
   localparam logic [POS_W-1:0] POS_LAST  = 5'd24;

   // (raw - 172) * 1000 / 1639 via reciprocal: floor(n * K / 2^22) is exact
   // for n up to 1875
   localparam logic signed [SCALED_W-1:0] RAW_OFFSET  = 12'sd172;
   localparam int unsigned                SCALE_SHIFT = 22;
   localparam logic [21:0]                SCALE_RECIP = 22'd2559063;

   localparam logic signed [SCALED_W-1:0] THR_BASE   = 12'sd1000;
   localparam logic signed [SCALED_W-1:0] CENTER_OFS = 12'sd500;

   typedef struct packed {
      logic [CHAN_W-1:0] chan2;
      logic [CHAN_W-1:0] chan1;
      logic [CHAN_W-1:0] chan0;
      logic              armed;
   } raw_frame_type;

endpackage

// ===== design/rcsfd_scale.sv =====
// ----------------------------------------------------------------------------
// rcsfd_scale
// Scales one 11-bit stick channel: (raw - 172) * 1000 / 1639, truncated
// toward zero, by a constant reciprocal multiply.
// ----------------------------------------------------------------------------
module rcsfd_scale (
   input  logic [rcsfd_pkg::CHAN_W-1:0]          raw,
   output logic signed [rcsfd_pkg::SCALED_W-1:0] scaled
);

   logic signed [rcsfd_pkg::SCALED_W-1:0] diff;
   logic signed [rcsfd_pkg::SCALED_W-1:0] diff_neg;
   logic [rcsfd_pkg::CHAN_W-1:0]          mag;
   logic [rcsfd_pkg::CHAN_W+21:0]         prod;
   logic [rcsfd_pkg::SCALED_W-1:0]        quot;

   assign diff     = $signed({1'b0, raw}) - rcsfd_pkg::RAW_OFFSET;
   assign diff_neg = -diff;
   assign mag      = diff[rcsfd_pkg::SCALED_W-1] ? diff_neg[rcsfd_pkg::CHAN_W-1:0]
                                                 : diff[rcsfd_pkg::CHAN_W-1:0];
   assign prod     = {22'd0, mag} * {{rcsfd_pkg::CHAN_W{1'b0}}, rcsfd_pkg::SCALE_RECIP};
   assign quot     = {1'b0, prod[rcsfd_pkg::SCALE_SHIFT +: rcsfd_pkg::CHAN_W]};
   assign scaled   = diff[rcsfd_pkg::SCALED_W-1] ? -$signed(quot) : $signed(quot);

endmodule

// ===== design/rc_serial_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder
// Collects 25-byte serial RC frames and emits the first three channels,
// their scaled commands and the arm flag.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. Bytes are dropped until 0x0F opens a
// frame; the 25th byte closes it and, if it is 0x00, one result beat follows
// through the raw channel register, then the scaled result register. A
// frame with a bad end byte gives no beat. A new byte is taken every cycle
// unless both pipeline registers hold results that the sink has not taken.
module rc_serial_frame_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] rx_data
   input  logic [rcsfd_pkg::BYTE_W-1:0]       req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [10:0] chan0_raw, [21:11] chan1_raw, [32:22] chan2_raw, [43:33] roll_cmd,
   // [54:44] pitch_cmd, [66:55] throttle_cmd, [67] armed, [71:68] zero
   output logic [rcsfd_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic                            req_fire;
   logic                            frame_done;
   logic                            en_a;
   logic                            en_b;

   logic [rcsfd_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [rcsfd_pkg::BYTE_W-1:0]    b1_ff, b2_ff, b3_ff, b4_ff;
   logic                            flag_ff;

   logic                            a_valid_ff, a_valid_in;
   rcsfd_pkg::raw_frame_type        a_ff, a_in;

   logic                            b_valid_ff, b_valid_in;
   logic [rcsfd_pkg::RSP_DATA_W-1:0] b_ff, b_in;

   logic signed [rcsfd_pkg::SCALED_W-1:0] s0, s1, s2;
   logic signed [rcsfd_pkg::SCALED_W-1:0] roll_w, pitch_w, thr_w;

   assign en_b       = !b_valid_ff || rsp_tready;
   assign en_a       = !a_valid_ff || en_b;
   assign req_tready = en_a;
   assign req_fire   = req_tvalid && en_a;
   assign frame_done = req_fire && (pos_ff == rcsfd_pkg::POS_LAST)
                       && (req_tdata == rcsfd_pkg::END_BYTE);

   // frame position
   always_comb begin
      pos_in = pos_ff;
      if (req_fire) begin
         if (pos_ff == rcsfd_pkg::POS_LAST) begin
            pos_in = '0;
         end else if (pos_ff != '0 || req_tdata == rcsfd_pkg::START_BYTE) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // only the bytes the result uses are kept
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (pos_ff == rcsfd_pkg::POS_B1)    b1_ff   <= req_tdata;
         if (pos_ff == rcsfd_pkg::POS_B2)    b2_ff   <= req_tdata;
         if (pos_ff == rcsfd_pkg::POS_B3)    b3_ff   <= req_tdata;
         if (pos_ff == rcsfd_pkg::POS_B4)    b4_ff   <= req_tdata;
         if (pos_ff == rcsfd_pkg::POS_FLAGS) flag_ff <= req_tdata[0];
      end
   end

   // stage A: unpacked raw channels
   always_comb begin
      a_in.chan0 = {b2_ff[2:0], b1_ff};
      a_in.chan1 = {b3_ff[5:0], b2_ff[7:3]};
      a_in.chan2 = {1'b0, b4_ff, b3_ff[7:6]};
      a_in.armed = flag_ff;
      a_valid_in = en_a ? frame_done : a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a && frame_done) begin
         a_ff <= a_in;
      end
   end

   // stage B: scaling into the result register
   rcsfd_scale u_scale0 (.raw(a_ff.chan0), .scaled(s0));
   rcsfd_scale u_scale1 (.raw(a_ff.chan1), .scaled(s1));
   rcsfd_scale u_scale2 (.raw(a_ff.chan2), .scaled(s2));

   assign roll_w  = s0 - rcsfd_pkg::CENTER_OFS;
   assign pitch_w = s1 - rcsfd_pkg::CENTER_OFS;
   assign thr_w   = s2 + rcsfd_pkg::THR_BASE;

   always_comb begin
      b_in = {{(rcsfd_pkg::RSP_DATA_W - rcsfd_pkg::RSP_BITS){1'b0}},
              a_ff.armed,
              thr_w[rcsfd_pkg::THR_W-1:0],
              pitch_w[rcsfd_pkg::CMD_W-1:0],
              roll_w[rcsfd_pkg::CMD_W-1:0],
              a_ff.chan2,
              a_ff.chan1,
              a_ff.chan0};
      b_valid_in = en_b ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b && a_valid_ff) begin
         b_ff <= b_in;
      end
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = b_ff;

endmodule
